>>> rtl/core/qn_pkg.sv
// shared constants for the quaternion normalizer
// no dependencies; imported by the top level
package qn_pkg;

    // one lane per quaternion component: w, x, y, z
    localparam int NUM_LANES = 4;

endpackage

>>> rtl/core/qn_square.sv
// per-component front end: sign, magnitude and registered square
// depends on no other module
module qn_square #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           adv,
    input  logic [COMPONENT_WIDTH-1:0]     comp,
    output logic                           neg,
    output logic [2*COMPONENT_WIDTH-2:0]   sq
);

    localparam int CW = COMPONENT_WIDTH;

    logic            neg_next;
    logic [CW-1:0]   mag;
    logic [2*CW-1:0] prod;
    logic            neg_reg;
    logic [2*CW-2:0] sq_reg;

    // most negative code keeps its face value: magnitude 2^(cw-1) still fits unsigned
    assign neg_next = comp[CW-1];
    assign mag      = neg_next ? (~comp + CW'(1)) : comp;
    assign prod     = mag * mag;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_reg <= neg_next;
            sq_reg  <= prod[2*CW-2:0];
        end
    end

    assign neg = neg_reg;
    assign sq  = sq_reg;

endmodule

>>> rtl/core/qn_scale.sv
// per-component scaling lane: bit-serial pipelined search for
// round(a * 2^f / sqrt(s)), one result bit per stage; depends on no other module
module qn_scale #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS   = 14
) (
    input  logic                           clk,
    input  logic                           adv,
    input  logic                           neg,
    input  logic [2*COMPONENT_WIDTH-2:0]   sq,
    input  logic [2*COMPONENT_WIDTH:0]     s,
    input  logic                           zero,
    output logic [COMPONENT_WIDTH-1:0]     res
);

    localparam int CW  = COMPONENT_WIDTH;
    localparam int FB  = FRACTION_BITS;
    localparam int LWS = 2*CW + 2*FB + 7;
    localparam int XW  = (CW > FB + 2) ? CW : FB + 2;

    logic [2*CW-2:0]        sq_reg;
    logic                   neg_reg;

    logic signed [LWS-1:0]  p_reg [FB+1];
    logic signed [LWS-1:0]  q_reg [FB+1];
    logic signed [LWS-1:0]  t_reg [FB+1];
    logic signed [LWS-1:0]  s_reg [FB+1];
    logic [FB:0]            n_reg [FB+1];
    logic                   sg_reg [FB+1];

    logic signed [LWS-1:0]  s_ext;
    logic signed [XW-1:0]   val;
    logic [CW-1:0]          res_reg;

    // align square and sign with the merged sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg  <= sq;
            neg_reg <= neg;
        end
    end

    assign s_ext = $signed(LWS'(s));

    // p tracks (2n-1)^2 * s, q tracks (2n-1) * s; t is 4 * a^2 * 2^(2f)
    for (genvar k = 0; k <= FB; k++)
    begin : g_stage
        localparam int B = FB - k;
        logic signed [LWS-1:0] p_in, q_in, t_in, s_in, r, p_cand;
        logic [FB:0]           n_in;
        logic                  sg_in, take;

        if (k == 0)
        begin : g_first
            assign p_in  = s_ext;
            assign q_in  = -s_ext;
            assign t_in  = $signed(LWS'(sq_reg)) <<< (2*FB + 2);
            assign s_in  = s_ext;
            assign n_in  = '0;
            assign sg_in = neg_reg;
        end
        else
        begin : g_rest
            assign p_in  = p_reg[k-1];
            assign q_in  = q_reg[k-1];
            assign t_in  = t_reg[k-1];
            assign s_in  = s_reg[k-1];
            assign n_in  = n_reg[k-1];
            assign sg_in = sg_reg[k-1];
        end

        assign r      = q_in + (s_in <<< B);
        assign p_cand = p_in + (r <<< (B + 2));
        assign take   = (p_cand <= t_in);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                p_reg[k]  <= take ? p_cand : p_in;
                q_reg[k]  <= take ? (r + (s_in <<< B)) : q_in;
                t_reg[k]  <= t_in;
                s_reg[k]  <= s_in;
                n_reg[k]  <= take ? (n_in | ((FB+1)'(1) << B)) : n_in;
                sg_reg[k] <= sg_in;
            end
        end
    end

    assign val = sg_reg[FB] ? -$signed(XW'(n_reg[FB])) : $signed(XW'(n_reg[FB]));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= zero ? '0 : val[CW-1:0];
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/core/quaternion_normalizer.sv
// quaternion normalizer top level: four component lanes, sum-of-squares merge, output register
// depends on qn_pkg, qn_square and qn_scale
//
// Takes one quaternion per transfer and returns it scaled to unit length, each component
// rounded to nearest (ties away from zero) in the input's fixed-point format. One item is
// accepted every cycle unless the output side stalls; the result search resolves one result
// bit per pipeline stage in each of the four lanes. An all-zero input gives all-zero
// components with zero_length set. A stall on the output side holds the whole pipeline.
module quaternion_normalizer #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS   = 14
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // in_w, in_x, in_y, in_z, then zero fill to whole bytes
    input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // out_w, out_x, out_y, out_z, then zero fill to whole bytes
    output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    // zero_length
    output logic                                      m_axis_tuser
);

    import qn_pkg::*;

    localparam int CW  = COMPONENT_WIDTH;
    localparam int FB  = FRACTION_BITS;
    localparam int TDW = ((4*CW + 7) / 8) * 8;
    localparam int LAT = FB + 4;

    logic                 adv;
    logic [LAT-1:0]       valid_reg;
    logic [LAT-1:0]       valid_next;
    logic                 neg  [NUM_LANES];
    logic [2*CW-2:0]      sq   [NUM_LANES];
    logic [CW-1:0]        res  [NUM_LANES];
    logic [2*CW:0]        s_next;
    logic [2*CW:0]        s_reg;
    logic [FB+1:0]        zero_reg;
    logic                 zl_reg;
    logic [4*CW-1:0]      out_packed;

    // whole pipeline moves unless the output register is full and held
    assign adv           = !valid_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign valid_next    = {valid_reg[LAT-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        qn_square #(
            .COMPONENT_WIDTH (CW)
        ) u_square (
            .clk  (clk),
            .adv  (adv),
            .comp (s_axis_tdata[i*CW +: CW]),
            .neg  (neg[i]),
            .sq   (sq[i])
        );

        qn_scale #(
            .COMPONENT_WIDTH (CW),
            .FRACTION_BITS   (FB)
        ) u_scale (
            .clk  (clk),
            .adv  (adv),
            .neg  (neg[i]),
            .sq   (sq[i]),
            .s    (s_reg),
            .zero (zero_reg[FB+1]),
            .res  (res[i])
        );

        assign out_packed[i*CW +: CW] = res[i];
    end

    // merge the four lane squares
    assign s_next = (2*CW+1)'(sq[0]) + (2*CW+1)'(sq[1])
                  + (2*CW+1)'(sq[2]) + (2*CW+1)'(sq[3]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg    <= s_next;
            zero_reg <= {zero_reg[FB:0], (s_next == '0)};
            zl_reg   <= zero_reg[FB+1];
        end
    end

    assign m_axis_tvalid = valid_reg[LAT-1];
    assign m_axis_tdata  = TDW'(out_packed);
    assign m_axis_tuser  = zl_reg;

    a_zero_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("zero-length result carries nonzero data");

    a_nonzero_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata != '0)
        else $error("nonzero quaternion normalized to all zeros");

    a_ready_follows_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready disagrees with output stall");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s_reg) && $stable(zero_reg))
        else $error("pipeline moved during a stall");

endmodule
